### rtl/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// widths, register codes and the shared side-data type of the particle drag force pipeline
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int ID_W    = 16;
    localparam int VEL_W   = 24;
    localparam int ABS_W   = 24;
    localparam int SQ_W    = 48;
    localparam int ROOT_W  = 24;
    localparam int COEF_W  = 20;
    localparam int PROD_W  = COEF_W + ROOT_W;
    localparam int FACT_W  = PROD_W + 1;
    localparam int LO_W    = 24;
    localparam int HI_W    = FACT_W - LO_W;
    localparam int PHI_W   = ABS_W + HI_W;
    localparam int PLO_W   = ABS_W + LO_W;
    localparam int MAG_W   = PHI_W + 1;
    localparam int FORCE_W = 32;
    localparam int K1_SHIFT = 12;
    localparam int LANES   = 3;

    // accept edge to result strobe, in clock edges
    localparam int LATENCY = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUADRATIC = 2'd1;

    localparam logic [COEF_W-1:0] K1_RESET = 20'd58982;
    localparam logic [COEF_W-1:0] K2_RESET = 20'd52429;

    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_NEG_MIN = 32'h8000_0000;

    // per item data that rides along the pipeline
    typedef struct packed {
        logic [ID_W-1:0]             id;
        logic [LANES-1:0][ABS_W-1:0] mag;
        logic [LANES-1:0]            neg;
    } side_t;

endpackage

### rtl/pdf_front.sv
// ----------------------------------------------------------------------------
// pdf_front
// absolute values, squares and sum of squares, three register stages
// ----------------------------------------------------------------------------
module pdf_front
    import pdf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic [ID_W-1:0]         in_id,
    input  logic signed [VEL_W-1:0] in_vel_x,
    input  logic signed [VEL_W-1:0] in_vel_y,
    input  logic signed [VEL_W-1:0] in_vel_z,
    output logic                    out_vld,
    output logic [SQ_W-1:0]         out_sum,
    output side_t                   out_side
);

    logic                         a_vld_reg, a_vld_next;
    side_t                        a_side_reg, a_side_next;
    logic                         b_vld_reg;
    side_t                        b_side_reg;
    logic [LANES-1:0][SQ_W-1:0]   b_sq_reg, b_sq_next;
    logic                         c_vld_reg;
    side_t                        c_side_reg;
    logic [SQ_W-1:0]              c_sum_reg, c_sum_next;
    logic [LANES-1:0][VEL_W-1:0]  vel;

    assign vel[0] = in_vel_x;
    assign vel[1] = in_vel_y;
    assign vel[2] = in_vel_z;

    // a zero velocity vector gives no result: drop it at the door
    assign a_vld_next = in_vld && ((in_vel_x != '0) || (in_vel_y != '0) || (in_vel_z != '0));

    always_comb
    begin
        a_side_next.id = in_id;
        for (int i = 0; i < LANES; i++)
        begin
            a_side_next.neg[i] = vel[i][VEL_W-1];
            a_side_next.mag[i] = vel[i][VEL_W-1] ? (~vel[i] + ABS_W'(1)) : vel[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            b_sq_next[i] = SQ_W'(a_side_reg.mag[i]) * SQ_W'(a_side_reg.mag[i]);
        end
    end

    assign c_sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
        b_side_reg <= a_side_reg;
        b_sq_reg   <= b_sq_next;
        c_side_reg <= b_side_reg;
        c_sum_reg  <= c_sum_next;
    end

    assign out_vld  = c_vld_reg;
    assign out_sum  = c_sum_reg;
    assign out_side = c_side_reg;

endmodule

### rtl/pdf_isqrt.sv
// ----------------------------------------------------------------------------
// pdf_isqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module pdf_isqrt
    import pdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [SQ_W-1:0]   in_val,
    input  side_t             in_side,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    localparam int REM_W = SQ_W + 1;

    logic [ROOT_W-1:0] vld_reg;
    logic [SQ_W-1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    side_t             side_reg  [ROOT_W];
    logic [SQ_W-1:0]   rem_in    [ROOT_W];
    logic [ROOT_W-1:0] root_in   [ROOT_W];
    logic [SQ_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [REM_W-1:0]  trial     [ROOT_W];

    always_comb
    begin
        rem_in[0]  = in_val;
        root_in[0] = '0;
        for (int j = 1; j < ROOT_W; j++)
        begin
            rem_in[j]  = rem_reg[j-1];
            root_in[j] = root_reg[j-1];
        end
        // stage j decides root bit ROOT_W-1-j: (q + 2^i)^2 - q^2 = q*2^(i+1) + 2^(2i)
        for (int j = 0; j < ROOT_W; j++)
        begin
            trial[j] = (REM_W'(root_in[j]) << (ROOT_W - j))
                     + (REM_W'(1) << (2 * (ROOT_W - 1 - j)));
            if (REM_W'(rem_in[j]) >= trial[j])
            begin
                rem_next[j]  = rem_in[j] - trial[j][SQ_W-1:0];
                root_next[j] = root_in[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            end
            else
            begin
                rem_next[j]  = rem_in[j];
                root_next[j] = root_in[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int j = 1; j < ROOT_W; j++)
        begin
            side_reg[j] <= side_reg[j-1];
        end
        for (int j = 0; j < ROOT_W; j++)
        begin
            rem_reg[j]  <= rem_next[j];
            root_reg[j] <= root_next[j];
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];

endmodule

### rtl/pdf_scale.sv
// ----------------------------------------------------------------------------
// pdf_scale
// drag factor, per-axis scaling, saturation and result register
// ----------------------------------------------------------------------------
module pdf_scale
    import pdf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  logic [ROOT_W-1:0]         in_root,
    input  side_t                     in_side,
    input  logic [COEF_W-1:0]         k1,
    input  logic [COEF_W-1:0]         k2,
    output logic                      done,
    output logic [ID_W-1:0]           particle_id_out,
    output logic signed [FORCE_W-1:0] force_x,
    output logic signed [FORCE_W-1:0] force_y,
    output logic signed [FORCE_W-1:0] force_z,
    output logic                      saturated
);

    logic                          f1_vld_reg;
    side_t                         f1_side_reg;
    logic [PROD_W-1:0]             f1_prod_reg, f1_prod_next;
    logic                          f2_vld_reg;
    side_t                         f2_side_reg;
    logic [FACT_W-1:0]             f2_fact_reg, f2_fact_next;
    logic                          m_vld_reg;
    side_t                         m_side_reg;
    logic [LANES-1:0][PHI_W-1:0]   m_hi_reg, m_hi_next;
    logic [LANES-1:0][PLO_W-1:0]   m_lo_reg, m_lo_next;
    logic                          s_vld_reg;
    side_t                         s_side_reg;
    logic [LANES-1:0][MAG_W-1:0]   s_mag_reg, s_mag_next;
    logic                          done_reg;
    logic [ID_W-1:0]               id_reg;
    logic [LANES-1:0][FORCE_W-1:0] force_reg, force_next;
    logic                          sat_reg, sat_next;
    logic [LANES-1:0]              lane_sat;

    assign f1_prod_next = PROD_W'(k2) * PROD_W'(in_root);
    assign f2_fact_next = FACT_W'(f1_prod_reg) + (FACT_W'(k1) << K1_SHIFT);

    // split the factor so each product stays near 24 x 24
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            m_hi_next[i] = PHI_W'(f2_side_reg.mag[i]) * PHI_W'(f2_fact_reg[FACT_W-1:LO_W]);
            m_lo_next[i] = PLO_W'(f2_side_reg.mag[i]) * PLO_W'(f2_fact_reg[LO_W-1:0]);
            s_mag_next[i] = MAG_W'(m_hi_reg[i]) + MAG_W'(m_lo_reg[i][PLO_W-1:LO_W]);
        end
    end

    // force opposes velocity; clamp magnitudes of 2^31 and above
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lane_sat[i] = |s_mag_reg[i][MAG_W-1:FORCE_W-1];
            if (s_side_reg.neg[i])
            begin
                force_next[i] = lane_sat[i] ? FORCE_POS_MAX : s_mag_reg[i][FORCE_W-1:0];
            end
            else
            begin
                force_next[i] = lane_sat[i] ? FORCE_NEG_MIN
                                            : (~s_mag_reg[i][FORCE_W-1:0] + FORCE_W'(1));
            end
        end
        sat_next = |lane_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            s_vld_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= in_vld;
            f2_vld_reg <= f1_vld_reg;
            m_vld_reg  <= f2_vld_reg;
            s_vld_reg  <= m_vld_reg;
            done_reg   <= s_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_side_reg <= in_side;
        f1_prod_reg <= f1_prod_next;
        f2_side_reg <= f1_side_reg;
        f2_fact_reg <= f2_fact_next;
        m_side_reg  <= f2_side_reg;
        m_hi_reg    <= m_hi_next;
        m_lo_reg    <= m_lo_next;
        s_side_reg  <= m_side_reg;
        s_mag_reg   <= s_mag_next;
        id_reg      <= s_side_reg.id;
        force_reg   <= force_next;
        sat_reg     <= sat_next;
    end

    assign done            = done_reg;
    assign particle_id_out = id_reg;
    assign force_x         = signed'(force_reg[0]);
    assign force_y         = signed'(force_reg[1]);
    assign force_z         = signed'(force_reg[2]);
    assign saturated       = sat_reg;

endmodule

### rtl/particle_drag_force.sv
// ----------------------------------------------------------------------------
// particle_drag_force
// linear plus quadratic drag force on one particle per transaction
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------------
//  command   start / busy            particle_id, vel_x, vel_y, vel_z
//  result    done (one-cycle pulse)  particle_id_out, force_x/y/z, saturated
//  config    cfg_we                  cfg_index, cfg_data
//
//  fully pipelined: a transaction is taken on every clock, busy stays low
//  an item passes these stages in order from the accepting edge to done
//  (3 front stages, 24 square root stages, one root bit each, 5 scale stages)
//  the square root pipeline sets the depth; each stage is wide add/compare logic
//  or multipliers of about 24 x 24
//  reset clears the valid bits and loads the default coefficients
//  the receiver cannot stall, so the pipeline never holds
//
module particle_drag_force
    import pdf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ID_W-1:0]           particle_id,
    input  logic signed [VEL_W-1:0]   vel_x,
    input  logic signed [VEL_W-1:0]   vel_y,
    input  logic signed [VEL_W-1:0]   vel_z,
    output logic                      done,
    output logic [ID_W-1:0]           particle_id_out,
    output logic signed [FORCE_W-1:0] force_x,
    output logic signed [FORCE_W-1:0] force_y,
    output logic signed [FORCE_W-1:0] force_z,
    output logic                      saturated,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COEF_W-1:0]         cfg_data
);

    logic              accept;
    logic [COEF_W-1:0] k1_reg, k1_next;
    logic [COEF_W-1:0] k2_reg, k2_next;
    logic              front_vld;
    logic [SQ_W-1:0]   front_sum;
    side_t             front_side;
    logic              sqrt_vld;
    logic [ROOT_W-1:0] sqrt_root;
    side_t             sqrt_side;

    // every stage advances each clock, so a new command is always welcome
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // coefficient registers; indexes past the list are ignored
    always_comb
    begin
        k1_next = k1_reg;
        k2_next = k2_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LINEAR:    k1_next = cfg_data;
                REG_QUADRATIC: k2_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= K1_RESET;
            k2_reg <= K2_RESET;
        end
        else
        begin
            k1_reg <= k1_next;
            k2_reg <= k2_next;
        end
    end

    // |v| per axis and sum of squares; zero vectors leave here without a valid bit
    pdf_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (accept),
        .in_id    (particle_id),
        .in_vel_x (vel_x),
        .in_vel_y (vel_y),
        .in_vel_z (vel_z),
        .out_vld  (front_vld),
        .out_sum  (front_sum),
        .out_side (front_side)
    );

    // speed = floor(sqrt(sum)), Q12.12
    pdf_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (front_vld),
        .in_val   (front_sum),
        .in_side  (front_side),
        .out_vld  (sqrt_vld),
        .out_root (sqrt_root),
        .out_side (sqrt_side)
    );

    // factor = k1*2^12 + k2*speed, force = -v * factor / 2^24, clamped to 32 bits
    pdf_scale u_scale
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_vld          (sqrt_vld),
        .in_root         (sqrt_root),
        .in_side         (sqrt_side),
        .k1              (k1_reg),
        .k2              (k2_reg),
        .done            (done),
        .particle_id_out (particle_id_out),
        .force_x         (force_x),
        .force_y         (force_y),
        .force_z         (force_z),
        .saturated       (saturated)
    );

`ifndef SYNTHESIS
    // a nonzero velocity always produces a result after the pipeline depth
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((vel_x != '0) || (vel_y != '0) || (vel_z != '0))) |-> ##LATENCY done)
        else $error("nonzero velocity transaction produced no result");

    // a zero velocity leaves an empty slot behind it
    a_zero_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (vel_x == '0) && (vel_y == '0) && (vel_z == '0)) |-> ##LATENCY !done)
        else $error("zero velocity transaction produced a result");

    // a clamp flag needs at least one component sitting at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |->
            ((force_x == FORCE_POS_MAX) || (force_x == FORCE_NEG_MIN) ||
             (force_y == FORCE_POS_MAX) || (force_y == FORCE_NEG_MIN) ||
             (force_z == FORCE_POS_MAX) || (force_z == FORCE_NEG_MIN)))
        else $error("saturated flag without a clamped component");

    // the negative rail is only reached through clamping
    a_neg_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !saturated) |->
            ((force_x != FORCE_NEG_MIN) && (force_y != FORCE_NEG_MIN) &&
             (force_z != FORCE_NEG_MIN)))
        else $error("negative rail reached without saturated flag");
`endif

endmodule
